// ===== hdl/gns_pkg.sv =====
// Shared types and constants of the grid normal stencil.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package gns_pkg;

    // Field widths. Positions carry 8 fraction bits and normals 16 fraction bits.
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int NORM_W     = 51;
    localparam int IDX_W      = 8;
    localparam int CFG_W      = 9;

    // Grid size lower limit and the size in force after reset.
    localparam int SIZE_MIN   = 3;
    localparam int SIZE_RESET = 128;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [NORM_W-1:0]  t_norm;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    // What the front decided about one vertex.
    typedef struct packed {
        logic interior;
        logic last_row;
    } t_flags;

endpackage

`default_nettype wire

// ===== hdl/gns_ifs.sv =====
// Handshake channels of the grid normal stencil: vertex input and normal output.
// Depends on gns_pkg for the payload types.
`default_nettype none

interface gns_vtx_if;
    logic            valid;
    logic            ready;
    gns_pkg::t_coord pos_x;
    gns_pkg::t_coord pos_y;
    gns_pkg::t_coord pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface gns_nrm_if;
    logic                          valid;
    logic                          ready;
    gns_pkg::t_norm                norm_x;
    gns_pkg::t_norm                norm_y;
    gns_pkg::t_norm                norm_z;
    logic [gns_pkg::IDX_W-1:0]     vertex_row;
    logic [gns_pkg::IDX_W-1:0]     vertex_col;
    logic                          run_last;

    modport source (output valid, output norm_x, output norm_y, output norm_z,
                    output vertex_row, output vertex_col, output run_last, input ready);
    modport sink   (input valid, input norm_x, input norm_y, input norm_z,
                    input vertex_row, input vertex_col, input run_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/grid_normal_stencil.sv =====
// Top level of the grid normal stencil: front, queue and back.
// Depends on gns_pkg, gns_ifs, gns_front, gns_queue and gns_back.
//
// Vertex positions of a square grid enter in raster order, one per cycle while
// neither the queue nor the output stalls, and normals leave one row late:
// each vertex from the second row on yields the normal of the vertex above it
// (a cross product of central differences for interior vertices, zero on the
// border), and each vertex of the last row also yields its own zero normal,
// so there the single output register, which holds both beats, slows intake.
// An accepted vertex reaches its first output beat through the line store
// read register, the queue, the difference stage, the multiplier stage and
// the output register. The line store is one memory of two rows with one
// write and two read ports; it needs no clearing pass after reset.
// Writing grid_size restarts the grid at row zero, column zero.
`default_nettype none

module grid_normal_stencil #(
    parameter int MAX_GRID = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [gns_pkg::CFG_W-1:0] i_cfg_wr_data,
    gns_vtx_if.sink                        i_vtx,
    gns_nrm_if.source                      o_nrm
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int QW = 3 * $bits(gns_pkg::t_pos) + 2 * CW + $bits(gns_pkg::t_flags);

    logic            q_push, q_pop, q_empty, q_full;
    logic [QW-1:0]   q_wdata, q_rdata;
    gns_pkg::t_pos   f_pos, f_rd_a, f_rd_b;
    gns_pkg::t_pos   b_pos, b_rd_a, b_rd_b;
    logic [CW-1:0]   f_row, f_col, b_row, b_col;
    gns_pkg::t_flags f_flags, b_flags;

    gns_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_vtx         (i_vtx),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_pos         (f_pos),
        .o_rd_a        (f_rd_a),
        .o_rd_b        (f_rd_b),
        .o_row         (f_row),
        .o_col         (f_col),
        .o_flags       (f_flags)
    );

    assign q_wdata = {f_pos, f_rd_a, f_rd_b, f_row, f_col, f_flags};

    gns_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_pos, b_rd_a, b_rd_b, b_row, b_col, b_flags} = q_rdata;

    gns_back #(
        .MAX_GRID (MAX_GRID)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_pos   (b_pos),
        .i_rd_a  (b_rd_a),
        .i_rd_b  (b_rd_b),
        .i_row   (b_row),
        .i_col   (b_col),
        .i_flags (b_flags),
        .o_nrm   (o_nrm)
    );

endmodule

`default_nettype wire

// ===== hdl/gns_front.sv =====
// Front of the grid normal stencil: raster counters, grid size register,
// two-row line store and classification. Depends on gns_pkg and gns_ifs.
`default_nettype none

module gns_front #(
    parameter int MAX_GRID = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [gns_pkg::CFG_W-1:0]     i_cfg_wr_data,
    gns_vtx_if.sink                            i_vtx,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output gns_pkg::t_pos                      o_pos,
    output gns_pkg::t_pos                      o_rd_a,
    output gns_pkg::t_pos                      o_rd_b,
    output logic [$clog2(MAX_GRID)-1:0]        o_row,
    output logic [$clog2(MAX_GRID)-1:0]        o_col,
    output gns_pkg::t_flags                    o_flags
);

    localparam int CW       = $clog2(MAX_GRID);
    localparam int AW       = CW + 1;
    localparam int SW       = (CW + 1 > gns_pkg::CFG_W) ? CW + 1 : gns_pkg::CFG_W;
    localparam int RST_SIZE = (gns_pkg::SIZE_RESET > MAX_GRID) ? MAX_GRID
                                                                : gns_pkg::SIZE_RESET;

    logic [CW-1:0]   r_last, n_last;
    logic [CW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [SW-1:0]   cfg_ext, cfg_clamp;
    logic            accept;
    logic [AW-1:0]   addr_wr, addr_a, addr_b;
    gns_pkg::t_flags flags;

    logic            r_s1_v;
    gns_pkg::t_pos   r_pos, r_rd_a, r_rd_b;
    logic [CW-1:0]   r_s1_row, r_s1_col;
    gns_pkg::t_flags r_s1_flags;

    // Two row buffers; row r lives in half r mod 2.
    gns_pkg::t_pos   r_mem [0:(1 << AW)-1];

    // A vertex is taken whenever the front register is free or can move on.
    assign accept      = i_vtx.valid && i_vtx.ready;
    assign i_vtx.ready = !r_s1_v || !i_q_full;
    assign o_push      = r_s1_v && !i_q_full;

    // Clamp the written size to the supported range and keep size minus one.
    always_comb begin
        cfg_ext = SW'(i_cfg_wr_data);
        priority if (cfg_ext < SW'(gns_pkg::SIZE_MIN)) begin
            cfg_clamp = SW'(gns_pkg::SIZE_MIN);
        end else if (cfg_ext > SW'(MAX_GRID)) begin
            cfg_clamp = SW'(MAX_GRID);
        end else begin
            cfg_clamp = cfg_ext;
        end
        n_last = CW'(cfg_clamp - SW'(1));
    end

    // Raster position of the next vertex.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            if (r_col == r_last) begin
                n_col = '0;
                n_row = (r_row == r_last) ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // Port A fetches the row above one column ahead. Port B fetches two rows
    // up in the same column, or the row above at column zero to seed the window.
    assign addr_wr = {r_row[0], r_col};
    assign addr_a  = {~r_row[0], r_col + CW'(1)};
    assign addr_b  = (r_col == '0) ? {~r_row[0], {CW{1'b0}}} : addr_wr;

    // Only vertices off the grid border get a computed normal.
    assign flags.interior = (r_row >= CW'(2)) && (r_col != '0) && (r_col < r_last);
    assign flags.last_row = (r_row == r_last);

    // Counters and size register; a size write restarts the grid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_last <= CW'(RST_SIZE - 1);
        end else if (i_cfg_wr_en) begin
            r_row  <= '0;
            r_col  <= '0;
            r_last <= n_last;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    // Front register holds a vertex that has results until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= (r_row != '0);
        end else if (o_push) begin
            r_s1_v <= 1'b0;
        end
    end

    // Line store write and registered reads; reads see the old contents.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[addr_wr] <= '{x: i_vtx.pos_x, y: i_vtx.pos_y, z: i_vtx.pos_z};
            r_rd_a         <= r_mem[addr_a];
            r_rd_b         <= r_mem[addr_b];
            r_pos          <= '{x: i_vtx.pos_x, y: i_vtx.pos_y, z: i_vtx.pos_z};
            r_s1_row       <= r_row;
            r_s1_col       <= r_col;
            r_s1_flags     <= flags;
        end
    end

    assign o_pos   = r_pos;
    assign o_rd_a  = r_rd_a;
    assign o_rd_b  = r_rd_b;
    assign o_row   = r_s1_row;
    assign o_col   = r_s1_col;
    assign o_flags = r_s1_flags;

endmodule

`default_nettype wire

// ===== hdl/gns_queue.sv =====
// Short queue between the front and the back of the grid normal stencil.
// Depends on gns_pkg for its depth.
`default_nettype none

module gns_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty,
    output logic              o_full
);

    logic [gns_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [gns_pkg::Q_AW:0]   r_count;
    logic [W-1:0]             r_slot [0:gns_pkg::Q_DEPTH-1];
    logic                     do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (gns_pkg::Q_AW + 1)'(gns_pkg::Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + gns_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + gns_pkg::Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (gns_pkg::Q_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (gns_pkg::Q_AW + 1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gns_back.sv =====
// Back of the grid normal stencil: neighbor window, differences, cross product
// and the output register. Depends on gns_pkg and gns_ifs.
`default_nettype none

module gns_back #(
    parameter int MAX_GRID = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    input  wire gns_pkg::t_pos                 i_pos,
    input  wire gns_pkg::t_pos                 i_rd_a,
    input  wire gns_pkg::t_pos                 i_rd_b,
    input  wire logic [$clog2(MAX_GRID)-1:0]   i_row,
    input  wire logic [$clog2(MAX_GRID)-1:0]   i_col,
    input  wire gns_pkg::t_flags               i_flags,
    gns_nrm_if.source                          o_nrm
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int RW = (CW > gns_pkg::IDX_W) ? CW : gns_pkg::IDX_W;
    localparam int PW = gns_pkg::PROD_W;
    localparam int NW = gns_pkg::NORM_W;
    localparam int DW = gns_pkg::DIFF_W;

    logic            adv;
    logic            out_acc;
    logic [CW-1:0]   row_sel;

    // Row above, one column back and two columns back.
    gns_pkg::t_pos   r_h1, r_h2;

    // Difference stage.
    logic            r_v1;
    logic [CW-1:0]   r_row1, r_col1;
    gns_pkg::t_flags r_fl1;
    gns_pkg::t_dvec  r_da, r_db;

    // Product stage.
    logic            r_v2;
    logic [CW-1:0]   r_row2, r_col2;
    gns_pkg::t_flags r_fl2;
    gns_pkg::t_prod  r_p_ybz, r_p_zby, r_p_zbx, r_p_xbz, r_p_xby, r_p_ybx;

    // Output register; r_ph marks the trailing zero normal of a last-row vertex.
    logic            r_v3, r_ph;
    logic [CW-1:0]   r_row3, r_col3;
    gns_pkg::t_flags r_fl3;
    gns_pkg::t_norm  r_nx, r_ny, r_nz;

    assign out_acc = o_nrm.valid && o_nrm.ready;
    // The stages move together whenever the output register is free or empties.
    assign adv     = !r_v3 || (o_nrm.ready && (r_ph || !r_fl3.last_row));
    assign o_pop   = adv && !i_empty;

    // Stage valid bits and the second-beat marker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ph <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ph <= 1'b0;
        end else if (out_acc && !r_ph && r_fl3.last_row) begin
            r_ph <= 1'b1;
        end
    end

    // Window over the row above; column zero seeds it from both read ports.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_col == '0) begin
                r_h1 <= i_rd_a;
                r_h2 <= i_rd_b;
            end else begin
                r_h2 <= r_h1;
                r_h1 <= i_rd_a;
            end
        end
    end

    // Row difference (this row minus two up) and column difference above.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_row1 <= i_row;
            r_col1 <= i_col;
            r_fl1  <= i_flags;
            r_da.x <= DW'(i_pos.x) - DW'(i_rd_b.x);
            r_da.y <= DW'(i_pos.y) - DW'(i_rd_b.y);
            r_da.z <= DW'(i_pos.z) - DW'(i_rd_b.z);
            r_db.x <= DW'(i_rd_a.x) - DW'(r_h2.x);
            r_db.y <= DW'(i_rd_a.y) - DW'(r_h2.y);
            r_db.z <= DW'(i_rd_a.z) - DW'(r_h2.z);
        end
    end

    // Six products of the cross product.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            r_fl2   <= r_fl1;
            r_p_ybz <= PW'(r_da.y) * PW'(r_db.z);
            r_p_zby <= PW'(r_da.z) * PW'(r_db.y);
            r_p_zbx <= PW'(r_da.z) * PW'(r_db.x);
            r_p_xbz <= PW'(r_da.x) * PW'(r_db.z);
            r_p_xby <= PW'(r_da.x) * PW'(r_db.y);
            r_p_ybx <= PW'(r_da.y) * PW'(r_db.x);
        end
    end

    // Cross product terms; border vertices take a zero normal.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_row3 <= r_row2;
            r_col3 <= r_col2;
            r_fl3  <= r_fl2;
            r_nx   <= r_fl2.interior ? NW'(r_p_ybz) - NW'(r_p_zby) : '0;
            r_ny   <= r_fl2.interior ? NW'(r_p_zbx) - NW'(r_p_xbz) : '0;
            r_nz   <= r_fl2.interior ? NW'(r_p_xby) - NW'(r_p_ybx) : '0;
        end
    end

    // First beat is the vertex one row up; the second beat is this vertex.
    assign row_sel            = r_ph ? r_row3 : r_row3 - CW'(1);
    assign o_nrm.valid        = r_v3;
    assign o_nrm.norm_x       = r_ph ? '0 : r_nx;
    assign o_nrm.norm_y       = r_ph ? '0 : r_ny;
    assign o_nrm.norm_z       = r_ph ? '0 : r_nz;
    assign o_nrm.vertex_row   = gns_pkg::IDX_W'(RW'(row_sel));
    assign o_nrm.vertex_col   = gns_pkg::IDX_W'(RW'(r_col3));
    assign o_nrm.run_last     = r_ph || !r_fl3.last_row;

endmodule

`default_nettype wire

// ===== hdl/gns_chk.sv =====
// Port-level checks of the grid normal stencil output channel, bound to the top.
// Depends on gns_pkg and on the grid_normal_stencil ports.
`default_nettype none

module gns_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      i_ready,
    input wire gns_pkg::t_norm            i_norm_x,
    input wire gns_pkg::t_norm            i_norm_y,
    input wire gns_pkg::t_norm            i_norm_z,
    input wire logic [gns_pkg::IDX_W-1:0] i_row,
    input wire logic [gns_pkg::IDX_W-1:0] i_col,
    input wire logic                      i_last
);

    // The output channel is empty right after reset.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

    // A stalled beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_norm_x) && $stable(i_norm_y)
            && $stable(i_norm_z) && $stable(i_row) && $stable(i_col) && $stable(i_last))
        else $error("stalled output beat changed");

    // A beat that is not the last of its vertex is followed at once by the
    // last-row vertex just below it.
    a_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid && i_last
            && i_col == $past(i_col) && i_row == $past(i_row) + 8'd1)
        else $error("second beat of a last-row vertex missing or misplaced");

    // That trailing beat belongs to the bottom border and carries a zero normal.
    a_follow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_norm_x == '0 && i_norm_y == '0
            && i_norm_z == '0)
        else $error("bottom border normal is not zero");

endmodule

bind grid_normal_stencil gns_chk u_gns_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_nrm.valid),
    .i_ready  (o_nrm.ready),
    .i_norm_x (o_nrm.norm_x),
    .i_norm_y (o_nrm.norm_y),
    .i_norm_z (o_nrm.norm_z),
    .i_row    (o_nrm.vertex_row),
    .i_col    (o_nrm.vertex_col),
    .i_last   (o_nrm.run_last)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench of the grid normal stencil: streams grids of vertex
// positions, predicts every normal beat and compares the output beats in order.
// Depends on gns_pkg, gns_ifs and the grid_normal_stencil top level.
`default_nettype none

module tb;

    localparam int MAX_GRID     = 256;
    localparam int ITEM_TARGET  = 1950;
    localparam int LARGE_ITEMS  = 2 * MAX_GRID + 24;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_REPORTS  = 10;

    localparam gns_pkg::t_coord POS_MAX  = {1'b0, {(gns_pkg::COORD_W-1){1'b1}}};
    localparam gns_pkg::t_coord POS_MIN  = {1'b1, {(gns_pkg::COORD_W-1){1'b0}}};
    localparam gns_pkg::t_coord POS_ZERO = '0;
    localparam gns_pkg::t_coord POS_ONE  = {{(gns_pkg::COORD_W-1){1'b0}}, 1'b1};
    localparam gns_pkg::t_coord POS_NEG1 = '1;

    // One normal beat as it leaves the block.
    typedef struct packed {
        gns_pkg::t_norm              nx;
        gns_pkg::t_norm              ny;
        gns_pkg::t_norm              nz;
        logic [gns_pkg::IDX_W-1:0]   row;
        logic [gns_pkg::IDX_W-1:0]   col;
        logic                        last;
    } t_normal_beat;

    // Tracks the grid state of the block and holds the normals still owed.
    class normal_scoreboard;
        gns_pkg::t_coord             line_x [2*MAX_GRID];
        gns_pkg::t_coord             line_y [2*MAX_GRID];
        gns_pkg::t_coord             line_z [2*MAX_GRID];
        logic [gns_pkg::CFG_W-1:0]   size_reg;
        int unsigned                 row_idx;
        int unsigned                 col_idx;
        t_normal_beat                owed_q [$];
        int                          errors;
        int                          normals_seen;
        int                          interior_count;

        function new();
            size_reg       = gns_pkg::CFG_W'(gns_pkg::SIZE_RESET);
            row_idx        = 0;
            col_idx        = 0;
            errors         = 0;
            normals_seen   = 0;
            interior_count = 0;
        endfunction

        // Effective grid size: the register clamped to the supported range.
        function int unsigned grid_span();
            if (size_reg < gns_pkg::SIZE_MIN) return gns_pkg::SIZE_MIN;
            if (size_reg > MAX_GRID) return MAX_GRID;
            return 32'(size_reg);
        endfunction

        // A size write restarts the grid but keeps the line stores.
        function void write_size(logic [gns_pkg::CFG_W-1:0] value);
            size_reg = value;
            row_idx  = 0;
            col_idx  = 0;
        endfunction

        // Works out the normals caused by one accepted vertex beat.
        function void note_vertex(gns_pkg::t_coord px, gns_pkg::t_coord py,
                                  gns_pkg::t_coord pz);
            int unsigned  n, r, c, cur, prv;
            longint       ax, ay, az, bx, by, bz;
            t_normal_beat b;
            n   = grid_span();
            r   = row_idx;
            c   = col_idx;
            cur = (r % 2) * MAX_GRID;
            prv = ((r + 1) % 2) * MAX_GRID;

            // Normal of the vertex one row up; zero on the border.
            if (r >= 1) begin
                b      = '0;
                b.row  = gns_pkg::IDX_W'(r - 1);
                b.col  = gns_pkg::IDX_W'(c);
                b.last = (r != n - 1);
                if (r - 1 >= 1 && r - 1 <= n - 2 && c >= 1 && c <= n - 2) begin
                    ax = longint'(px) - longint'(line_x[cur + c]);
                    ay = longint'(py) - longint'(line_y[cur + c]);
                    az = longint'(pz) - longint'(line_z[cur + c]);
                    bx = longint'(line_x[prv + c + 1]) - longint'(line_x[prv + c - 1]);
                    by = longint'(line_y[prv + c + 1]) - longint'(line_y[prv + c - 1]);
                    bz = longint'(line_z[prv + c + 1]) - longint'(line_z[prv + c - 1]);
                    b.nx = gns_pkg::t_norm'(ay * bz - az * by);
                    b.ny = gns_pkg::t_norm'(az * bx - ax * bz);
                    b.nz = gns_pkg::t_norm'(ax * by - ay * bx);
                    interior_count++;
                end
                owed_q.push_back(b);
            end

            line_x[cur + c] = px;
            line_y[cur + c] = py;
            line_z[cur + c] = pz;

            // The last row also owes its own zero normal.
            if (r == n - 1) begin
                b      = '0;
                b.row  = gns_pkg::IDX_W'(r);
                b.col  = gns_pkg::IDX_W'(c);
                b.last = 1'b1;
                owed_q.push_back(b);
            end

            // Raster advance with wrap to a new grid.
            if (c + 1 >= n) begin
                col_idx = 0;
                row_idx = (r + 1 >= n) ? 0 : r + 1;
            end else begin
                col_idx = c + 1;
            end
        endfunction

        // Compares one output beat with the oldest normal owed.
        function void check_normal(t_normal_beat got);
            t_normal_beat want;
            normals_seen++;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected normal beat at row %0d col %0d", got.row, got.col);
                return;
            end
            want = owed_q.pop_front();
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("Normal mismatch, expected row %0d col %0d last %0b n=(%0d, %0d, %0d)",
                             want.row, want.col, want.last, want.nx, want.ny, want.nz);
                    $display("                 actual   row %0d col %0d last %0b n=(%0d, %0d, %0d)",
                             got.row, got.col, got.last, got.nx, got.ny, got.nz);
                end
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [gns_pkg::CFG_W-1:0]   cfg_wr_data;
    int                          vtx_beats   = 0;
    int                          size_writes = 0;
    int                          holds_done  = 0;
    bit                          hold_req    = 1'b0;

    normal_scoreboard   sb = new();

    gns_vtx_if vtx ();
    gns_nrm_if nrm ();

    grid_normal_stencil #(
        .MAX_GRID(MAX_GRID)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_vtx        (vtx),
        .o_nrm        (nrm)
    );

    // Clock.
    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d normals still owed", sb.owed_q.size());
        $display("grid_normal_stencil verification failed");
        $finish;
    end

    // Random position: mostly full range, some small values and extremes.
    function automatic gns_pkg::t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2, 3:    return gns_pkg::t_coord'(int'($urandom_range(0, 2048)) - 1024);
            default: return gns_pkg::t_coord'($urandom());
        endcase
    endfunction

    // Offers one vertex beat, with random gaps, and waits until it is taken.
    task automatic send_vertex(input gns_pkg::t_coord px, input gns_pkg::t_coord py,
                               input gns_pkg::t_coord pz);
        logic took;
        while (!(vtx_beats >= 700 && vtx_beats < 1000) && $urandom_range(0, 99) < 32) begin
            vtx.valid <= 1'b0;
            @(posedge clk);
        end
        vtx.valid <= 1'b1;
        vtx.pos_x <= px;
        vtx.pos_y <= py;
        vtx.pos_z <= pz;
        do begin
            @(negedge clk);
            took = vtx.ready;
            @(posedge clk);
        end while (took !== 1'b1);
        sb.note_vertex(px, py, pz);
        vtx_beats++;
    endtask

    // Sends a run of random vertices; hold_at > 0 asks for an output hold-off.
    task automatic send_random(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (hold_at > 0 && i == hold_at) hold_req = 1'b1;
            send_vertex(rand_coord(), rand_coord(), rand_coord());
        end
        vtx.valid <= 1'b0;
    endtask

    // Writes grid_size once the block has drained.
    task automatic write_grid_size(input logic [gns_pkg::CFG_W-1:0] value);
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.write_size(value);
        size_writes++;
    endtask

    // Output side: random back-pressure, a steady stretch and one long hold-off.
    initial begin : normal_sink
        int unsigned stall_left;
        stall_left = 0;
        nrm.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                holds_done++;
            end
            if (stall_left != 0) begin
                stall_left--;
                nrm.ready <= 1'b0;
            end else if (sb.normals_seen >= 800 && sb.normals_seen < 1100) begin
                nrm.ready <= 1'b1;
            end else begin
                nrm.ready <= ($urandom_range(0, 99) >= 32);
            end
        end
    end

    // Output beats are sampled mid-cycle, where valid and ready are settled.
    always @(negedge clk) begin
        t_normal_beat got;
        if (rst_n === 1'b1 && nrm.valid === 1'b1 && nrm.ready === 1'b1) begin
            got.nx   = nrm.norm_x;
            got.ny   = nrm.norm_y;
            got.nz   = nrm.norm_z;
            got.row  = nrm.vertex_row;
            got.col  = nrm.vertex_col;
            got.last = nrm.run_last;
            sb.check_normal(got);
        end
    end

    initial begin : stimulus
        gns_pkg::t_coord             dir_x [9];
        gns_pkg::t_coord             dir_y [9];
        gns_pkg::t_coord             dir_z [9];
        logic [gns_pkg::CFG_W-1:0]   size_val;
        int                          n, n_items, budget;
        bit                          large_done;

        large_done  = 1'b0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        vtx.valid   <= 1'b0;
        vtx.pos_x   <= '0;
        vtx.pos_y   <= '0;
        vtx.pos_z   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size of 128: two rows and a part of a third, cut mid-grid below.
        send_random(300, 0);

        // A 3x3 grid whose center normal is built from the coordinate extremes.
        dir_x = '{POS_ZERO, POS_MIN, POS_NEG1, POS_MAX, POS_ONE, POS_MIN, POS_ZERO,
                  POS_MAX, POS_MAX};
        dir_y = '{POS_ZERO, POS_MAX, POS_NEG1, POS_MAX, POS_NEG1, POS_MIN, POS_ZERO,
                  POS_MIN, POS_MAX};
        dir_z = '{POS_ZERO, POS_MIN, POS_NEG1, POS_MIN, POS_ONE, POS_MAX, POS_ZERO,
                  POS_MAX, POS_MAX};
        write_grid_size(gns_pkg::CFG_W'(3));
        for (int i = 0; i < 9; i++) send_vertex(dir_x[i], dir_y[i], dir_z[i]);
        vtx.valid <= 1'b0;

        // Size zero clamps to three; the inverted grid flips every extreme.
        write_grid_size('0);
        for (int i = 0; i < 9; i++) send_vertex(~dir_x[i], ~dir_y[i], ~dir_z[i]);
        vtx.valid <= 1'b0;

        // Size two clamps as well; the grid is left unfinished.
        write_grid_size(gns_pkg::CFG_W'(2));
        for (int i = 0; i < 5; i++) send_vertex(dir_x[8 - i], dir_y[i], ~dir_z[i]);
        vtx.valid <= 1'b0;

        // Random grids, mostly small and whole, some cut short by the next write.
        // The item budget keeps room for the one large grid until it has run.
        while (vtx_beats < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:             size_val = gns_pkg::CFG_W'($urandom_range(0, 2));
                1, 2, 3, 4, 5: size_val = gns_pkg::CFG_W'($urandom_range(3, 8));
                default:       size_val = gns_pkg::CFG_W'($urandom_range(9, 20));
            endcase
            n       = (size_val < gns_pkg::SIZE_MIN) ? gns_pkg::SIZE_MIN : int'(size_val);
            n_items = n * n * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, n * n - 1);
            budget  = ITEM_TARGET - vtx_beats - (large_done ? 0 : LARGE_ITEMS);
            if (n_items > budget) n_items = budget;
            write_grid_size(size_val);
            send_random(n_items, 0);

            // Once: the largest register value, clamped to the full row length,
            // with the output held off while the input keeps coming.
            if (!large_done && vtx_beats >= 900) begin
                large_done = 1'b1;
                write_grid_size('1);
                send_random(LARGE_ITEMS, 300);
            end
        end

        // Drain.
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d vertex beats and %0d normal beats (%0d interior),",
                 vtx_beats, sb.normals_seen, sb.interior_count);
        $display("%0d size writes, grid sizes 3 to 256, %0d long output hold-off(s); %0d error(s).",
                 size_writes, holds_done, sb.errors);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("grid_normal_stencil verification clean");
        end else begin
            $display("grid_normal_stencil verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
